### sv/token_classifier_stream_defines.svh
// Assertion macros for the token classifier stream checker.
// Depends on nothing; the including module provides aclk and aresetn.
`ifndef TOKEN_CLASSIFIER_STREAM_DEFINES_SVH
`define TOKEN_CLASSIFIER_STREAM_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted
`define TCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted
`define TCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Checks the cycle that follows a reset edge
`define TCS_ASSERT_AFTER_RESET(label, cons, msg) \
    label: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error(msg);

`endif

### sv/tcs_pkg.sv
// Shared types, constants and word tables for the token classifier stream.
// No dependencies; imported by every module of the block.
package tcs_pkg;

    localparam int CharW    = 8;
    localparam int LenW     = 8;
    localparam int ClassW   = 3;
    localparam int NumWords = 14;

    localparam int MaxLengthDefault  = 255;
    localparam int QueueDepthDefault = 2;

    // Word groups inside the word table
    localparam int KwFirst  = 0;
    localparam int KwLast   = 5;
    localparam int SysFirst = 6;
    localparam int SysLast  = 8;
    localparam int OpFirst  = 9;
    localparam int OpLast   = 13;

    localparam logic [CharW-1:0] ChSpace = 8'd32;
    localparam logic [CharW-1:0] ChTab   = 8'd9;
    localparam logic [CharW-1:0] ChCr    = 8'd13;
    localparam logic [CharW-1:0] ChZero  = 8'h30;
    localparam logic [CharW-1:0] ChNine  = 8'h39;
    localparam logic [CharW-1:0] ChLowA  = 8'h61;
    localparam logic [CharW-1:0] ChLowZ  = 8'h7a;
    localparam logic [CharW-1:0] ChMinus = 8'h2d;

    typedef enum logic [ClassW-1:0] {
        CLS_KEYWORD    = 3'd0,
        CLS_SYSTEM     = 3'd1,
        CLS_OPERATOR   = 3'd2,
        CLS_LITERAL    = 3'd3,
        CLS_IDENTIFIER = 3'd4,
        CLS_INVALID    = 3'd5
    } tcs_class_t;

    // Word text, right-justified, first character in the highest used byte
    localparam logic [63:0] WordText [NumWords] = '{
        64'("vint"), 64'("cint"), 64'("last"), 64'("rename"), 64'("delete"),
        64'("comment"), 64'("hello"), 64'("clear"), 64'("exit"),
        64'("+"), 64'("-"), 64'("*"), 64'("/"), 64'("=")
    };

    localparam logic [2:0] WordLen [NumWords] = '{
        3'd4, 3'd4, 3'd4, 3'd6, 3'd6, 3'd7, 3'd5, 3'd5, 3'd4,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1
    };

    // Character at position pos of word idx; zero past the end of the word
    function automatic logic [CharW-1:0] word_char(input int idx, input logic [2:0] pos);
        int sh;
        sh = (int'(WordLen[idx]) - 1 - int'(pos)) * 8;
        if (sh < 0) begin
            return '0;
        end
        return WordText[idx][sh +: CharW];
    endfunction

    // Summary of one finished token
    typedef struct packed {
        logic [NumWords-1:0] match_mask;
        logic [LenW-1:0]     length;
        logic                first_digit;
        logic                first_minus;
        logic                rest_digits;
        logic                all_lower;
        logic                ends_line;
    } tcs_rec_t;

    typedef struct packed {
        logic     valid;
        tcs_rec_t rec;
    } tcs_push_t;

endpackage

### sv/tcs_front.sv
// Front end: takes one character per cycle unless q_full, tracks the
// open token and pushes a summary of each closed token. Depends on tcs_pkg.
module tcs_front
    import tcs_pkg::*;
#(
    parameter int MAX_LENGTH = MaxLengthDefault
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [CharW-1:0] s_tdata,
    input  logic             s_tlast,
    input  logic             q_full,
    output tcs_push_t        push
);

    localparam int              LenCapInt = (MAX_LENGTH < 255) ? MAX_LENGTH : 255;
    localparam logic [LenW-1:0] LenCap    = LenW'(LenCapInt);

    logic                inside_reg, inside_next;
    logic [LenW-1:0]     len_reg, len_next;
    logic [NumWords-1:0] mask_reg, mask_next;
    logic                fdig_reg, fdig_next;
    logic                fmin_reg, fmin_next;
    logic                rest_reg, rest_next;
    logic                lower_reg, lower_next;

    logic                accept;
    logic                is_space, is_digit, is_lower;
    logic [NumWords-1:0] keep;
    tcs_rec_t            rec_cur, rec_abs;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    assign is_space = (s_tdata == ChSpace) || (s_tdata >= ChTab && s_tdata <= ChCr);
    assign is_digit = (s_tdata >= ChZero) && (s_tdata <= ChNine);
    assign is_lower = (s_tdata >= ChLowA) && (s_tdata <= ChLowZ);

    always_comb begin
        for (int i = 0; i < NumWords; i++) begin
            keep[i] = (len_reg < {5'b0, WordLen[i]}) && (word_char(i, len_reg[2:0]) == s_tdata);
        end
    end

    always_comb begin
        rec_cur.match_mask  = mask_reg;
        rec_cur.length      = len_reg;
        rec_cur.first_digit = fdig_reg;
        rec_cur.first_minus = fmin_reg;
        rec_cur.rest_digits = rest_reg;
        rec_cur.all_lower   = lower_reg;
        rec_cur.ends_line   = s_tlast;

        rec_abs.match_mask  = mask_reg & keep;
        rec_abs.length      = (len_reg < LenCap) ? len_reg + 1'b1 : len_reg;
        rec_abs.first_digit = (len_reg == '0) ? is_digit : fdig_reg;
        rec_abs.first_minus = (len_reg == '0) ? (s_tdata == ChMinus) : fmin_reg;
        rec_abs.rest_digits = (len_reg == '0) ? rest_reg : (rest_reg && is_digit);
        rec_abs.all_lower   = lower_reg && is_lower;
        rec_abs.ends_line   = 1'b1;
    end

    always_comb begin
        logic clear_tok;
        clear_tok   = 1'b0;
        push.valid  = 1'b0;
        push.rec    = rec_abs;
        inside_next = inside_reg;
        len_next    = len_reg;
        mask_next   = mask_reg;
        fdig_next   = fdig_reg;
        fmin_next   = fmin_reg;
        rest_next   = rest_reg;
        lower_next  = lower_reg;
        if (accept) begin
            if (is_space) begin
                // close the open token, if any
                push.valid = inside_reg;
                push.rec   = rec_cur;
                clear_tok  = 1'b1;
            end else if (s_tlast) begin
                push.valid = 1'b1;
                clear_tok  = 1'b1;
            end else begin
                inside_next = 1'b1;
                len_next    = rec_abs.length;
                mask_next   = rec_abs.match_mask;
                fdig_next   = rec_abs.first_digit;
                fmin_next   = rec_abs.first_minus;
                rest_next   = rec_abs.rest_digits;
                lower_next  = rec_abs.all_lower;
            end
        end
        if (clear_tok) begin
            inside_next = 1'b0;
            len_next    = '0;
            mask_next   = '1;
            fdig_next   = 1'b0;
            fmin_next   = 1'b0;
            rest_next   = 1'b1;
            lower_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg <= 1'b0;
            len_reg    <= '0;
            mask_reg   <= '1;
            fdig_reg   <= 1'b0;
            fmin_reg   <= 1'b0;
            rest_reg   <= 1'b1;
            lower_reg  <= 1'b1;
        end else begin
            inside_reg <= inside_next;
            len_reg    <= len_next;
            mask_reg   <= mask_next;
            fdig_reg   <= fdig_next;
            fmin_reg   <= fmin_next;
            rest_reg   <= rest_next;
            lower_reg  <= lower_next;
        end
    end

endmodule

### sv/tcs_queue.sv
// Short queue of token summaries between the front and back ends.
// Depends on tcs_pkg.
module tcs_queue
    import tcs_pkg::*;
#(
    parameter int DEPTH = QueueDepthDefault
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  tcs_push_t push,
    output logic      full,
    output logic      rd_valid,
    output tcs_rec_t  rd_rec,
    input  logic      pop
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    tcs_rec_t        entry_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_pop;

    assign full     = (count_reg == FullCnt);
    assign rd_valid = (count_reg != '0);
    assign rd_rec   = entry_reg[rd_ptr_reg];
    assign do_pop   = pop && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push.valid, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            entry_reg[wr_ptr_reg] <= push.rec;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/tcs_back.sv
// Back end: classifies queued token summaries and holds the result in an
// output register for the result channel. Depends on tcs_pkg.
module tcs_back
    import tcs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_valid,
    input  tcs_rec_t          rd_rec,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [LenW-1:0]   m_tdata,
    output logic [ClassW-1:0] m_tuser,
    output logic              m_tlast
);

    logic              valid_reg, valid_next;
    logic [ClassW-1:0] class_reg;
    logic [LenW-1:0]   len_reg;
    logic              ends_reg;
    logic              kw_hit, sys_hit, op_hit, lit_ok;
    tcs_class_t        cls;

    // a word matches when its bit survived and the length is exactly its length
    always_comb begin
        kw_hit  = 1'b0;
        sys_hit = 1'b0;
        op_hit  = 1'b0;
        for (int i = 0; i < NumWords; i++) begin
            if (rd_rec.match_mask[i] && rd_rec.length == {5'b0, WordLen[i]}) begin
                if (i <= KwLast) begin
                    kw_hit = 1'b1;
                end else if (i >= SysFirst && i <= SysLast) begin
                    sys_hit = 1'b1;
                end else if (i >= OpFirst && i <= OpLast) begin
                    op_hit = 1'b1;
                end
            end
        end
    end

    assign lit_ok = rd_rec.rest_digits && (rd_rec.first_digit ||
                    (rd_rec.first_minus && rd_rec.length >= LenW'(2)));

    always_comb begin
        priority if (kw_hit) begin
            cls = CLS_KEYWORD;
        end else if (sys_hit) begin
            cls = CLS_SYSTEM;
        end else if (op_hit) begin
            cls = CLS_OPERATOR;
        end else if (lit_ok) begin
            cls = CLS_LITERAL;
        end else if (rd_rec.all_lower) begin
            cls = CLS_IDENTIFIER;
        end else begin
            cls = CLS_INVALID;
        end
    end

    assign pop        = rd_valid && (!valid_reg || m_tready);
    assign valid_next = pop ? 1'b1 : (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (pop) begin
            class_reg <= cls;
            len_reg   <= rd_rec.length;
            ends_reg  <= rd_rec.ends_line;
        end
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = len_reg;
    assign m_tuser  = class_reg;
    assign m_tlast  = ends_reg;

endmodule

### sv/token_classifier_stream.sv
// Token classifier stream: top level joining front end, queue and back end.
// Depends on tcs_pkg, tcs_front, tcs_queue and tcs_back.
//
// One character of a text line enters per item on the slave side, with
// s_tlast on the line's last character. Whitespace (tab, line feed,
// vertical tab, form feed, carriage return, space) separates tokens. When
// a token closes, one result item leaves on the master side: its class in
// m_tuser (keyword, system keyword, operator, literal, identifier, invalid),
// its length in m_tdata, saturating at the smaller of MAX_LENGTH and 255,
// and m_tlast high when the line end closed it. A character is taken every
// cycle while the queue is not full: the front end updates the running
// match state with each accepted character, and a result passes through
// the queue and then the output register before it reaches m_tvalid. The
// queue of QUEUE_DEPTH summaries sits between the front and back ends;
// s_tready falls only when it is full, which happens when the result side
// stalls while further tokens keep closing.
module token_classifier_stream
    import tcs_pkg::*;
#(
    parameter int MAX_LENGTH  = MaxLengthDefault,
    parameter int QUEUE_DEPTH = QueueDepthDefault
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CharW-1:0]  s_tdata,   // [7:0] char_code
    input  logic              s_tlast,   // line_end
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [LenW-1:0]   m_tdata,   // [7:0] token_length
    output logic [ClassW-1:0] m_tuser,   // [2:0] token_class
    output logic              m_tlast    // ends_line
);

    tcs_push_t push;
    logic      q_full;
    logic      q_valid;
    tcs_rec_t  q_rec;
    logic      q_pop;

    // Track the open token and hand each closed one to the queue
    tcs_front #(
        .MAX_LENGTH(MAX_LENGTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .q_full  (q_full),
        .push    (push)
    );

    // Decouple character intake from result delivery
    tcs_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (q_full),
        .rd_valid(q_valid),
        .rd_rec  (q_rec),
        .pop     (q_pop)
    );

    // Classify and hold the result until the sink takes it
    tcs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_valid(q_valid),
        .rd_rec  (q_rec),
        .pop     (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

### sv/tcs_checker.sv
// Port-level checks on the result channel of the token classifier stream,
// bound to the top level. Depends on tcs_pkg and the assertion macro header.
`include "token_classifier_stream_defines.svh"

module tcs_checker
    import tcs_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [LenW-1:0]   m_tdata,
    input logic [ClassW-1:0] m_tuser,
    input logic              m_tlast
);

    `TCS_ASSERT_AFTER_RESET(a_idle_after_reset, !m_tvalid, "result valid after reset")
    `TCS_ASSERT_NEXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser, m_tlast}), "stalled result changed")
    `TCS_ASSERT_NOW(a_class_range, m_tvalid, m_tuser <= CLS_INVALID && m_tdata != '0, "bad class or empty token")
    `TCS_ASSERT_NOW(a_operator_len, m_tvalid && m_tuser == CLS_OPERATOR, m_tdata == LenW'(1), "operator longer than one")
    `TCS_ASSERT_NOW(a_keyword_len, m_tvalid && (m_tuser == CLS_KEYWORD || m_tuser == CLS_SYSTEM), m_tdata >= LenW'(4) && m_tdata <= LenW'(7), "keyword length off")

endmodule

bind token_classifier_stream tcs_checker u_tcs_checker (.*);
